// File: rtl/core/sprite_frame_animator_unit_defines.svh
// Assertion macros shared by the RTL of the sprite frame animator.
`ifndef SPRITE_FRAME_ANIMATOR_UNIT_DEFINES_SVH
`define SPRITE_FRAME_ANIMATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: implication failed");

`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// File: rtl/core/spr_anim_pkg.sv
`default_nettype none

package spr_anim_pkg;

    localparam int MAX_FRAMES_DEF = 256;
    localparam int TIME_BITS_DEF  = 24;
    localparam int COORD_BITS_DEF = 12;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;
    localparam int SIDE_BITS      = 11;
    localparam int POS_BITS       = 20;
    localparam int EXT_BITS       = 12;

    localparam logic [SIDE_BITS-1:0] MAX_SIDE = 11'd1024;

    localparam logic [2:0] REQ_TICK    = 3'd0;
    localparam logic [2:0] REQ_PLAY    = 3'd1;
    localparam logic [2:0] REQ_PAUSE   = 3'd2;
    localparam logic [2:0] REQ_STOP    = 3'd3;
    localparam logic [2:0] REQ_RESTART = 3'd4;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_TOTAL    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_START_X        = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_START_Y        = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHEET_WIDTH    = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_DURATION = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODE_BITS      = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADV,
        ST_DIV_SX,
        ST_DIV_SY,
        ST_DIV_SW,
        ST_DIV_FR,
        ST_MUL_X,
        ST_MUL_Y,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [23:0] delta_time;
    } in_item_t;

    typedef struct packed {
        logic signed [19:0] rect_left;
        logic signed [19:0] rect_top;
        logic signed [11:0] rect_width;
        logic signed [11:0] rect_height;
        logic [7:0]         frame_index;
        logic               playing;
        logic               frame_advanced;
    } out_item_t;

endpackage

`default_nettype wire

// File: rtl/core/sprite_frame_animator_unit.sv
// An accepted transaction passes ST_DIV_FR, ST_MUL_X, ST_MUL_Y and ST_OUT, after ST_ADV
// for a tick while playing; NB = max(COORD_BITS + 1, log2(MAX_FRAMES), 11), 13 by default.
// The first one after reset or any register write also runs ST_DIV_SX, ST_DIV_SY, ST_DIV_SW.
// One NB-bit restoring divider retiring one quotient bit per cycle serves all four divisions.
// One transaction at a time; ST_OUT waits on m_ready; s_ready returns with the result.
// Reset (aresetn low, synchronous): registers take their default values, frame and time clear.
`default_nettype none
`include "sprite_frame_animator_unit_defines.svh"

module sprite_frame_animator_unit #(
    parameter int MAX_FRAMES = spr_anim_pkg::MAX_FRAMES_DEF,
    parameter int TIME_BITS  = spr_anim_pkg::TIME_BITS_DEF,
    parameter int COORD_BITS = spr_anim_pkg::COORD_BITS_DEF
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    cfg_wr_en,
    input  wire logic [spr_anim_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [spr_anim_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire spr_anim_pkg::in_item_t                  s_data,
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output spr_anim_pkg::out_item_t                      m_data
);

    localparam int FRAME_BITS = $clog2(MAX_FRAMES);
    localparam int TOTAL_BITS = FRAME_BITS + 1;
    localparam int ACC_BITS   = TIME_BITS + 1;
    localparam int SW_BITS    = COORD_BITS + 1;
    localparam int SIDE_BITS  = spr_anim_pkg::SIDE_BITS;
    localparam int POS_BITS   = spr_anim_pkg::POS_BITS;
    localparam int EXT_BITS   = spr_anim_pkg::EXT_BITS;
    localparam int NB_A       = (SW_BITS > FRAME_BITS) ? SW_BITS : FRAME_BITS;
    localparam int NB         = (NB_A > SIDE_BITS) ? NB_A : SIDE_BITS;
    localparam int CNT_BITS   = $clog2(NB);
    localparam int PROD_BITS  = NB + 1 + SIDE_BITS;

    logic [8:0]           frame_total_reg;
    logic [SIDE_BITS-1:0] frame_width_reg;
    logic [SIDE_BITS-1:0] frame_height_reg;
    logic [11:0]          start_x_reg;
    logic [11:0]          start_y_reg;
    logic [12:0]          sheet_width_reg;
    logic [23:0]          frame_duration_reg;
    logic [2:0]           mode_bits_reg;

    spr_anim_pkg::state_t state_reg, state_next;

    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic [ACC_BITS-1:0]   accum_reg, accum_next;
    logic                  running_reg, running_next;
    logic                  adv_reg, adv_next;
    logic                  geom_valid_reg, geom_valid_next;

    logic [NB-1:0]       rem_reg, rem_next;
    logic [NB-1:0]       quo_reg, quo_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;

    logic [NB-1:0] colb_reg, colb_next;
    logic [NB-1:0] rowb_reg, rowb_next;
    logic [NB-1:0] cols_reg, cols_next;
    logic [NB-1:0] fq_reg, fq_next;
    logic [NB-1:0] fr_reg, fr_next;

    logic [POS_BITS-1:0] pos_x_reg, pos_x_next;
    logic [POS_BITS-1:0] pos_y_reg, pos_y_next;

    logic                    m_valid_reg, m_valid_next;
    spr_anim_pkg::out_item_t out_reg, out_next;

    logic [SIDE_BITS-1:0]  side_w;
    logic [SIDE_BITS-1:0]  side_h;
    logic [NB-1:0]         start_col_src;
    logic [NB-1:0]         start_row_src;
    logic [NB-1:0]         sheet_src;
    logic [TIME_BITS-1:0]  dur_raw;
    logic [ACC_BITS-1:0]   dur_eff;
    logic [31:0]           total_wide;
    logic [TOTAL_BITS-1:0] total_eff;
    logic [ACC_BITS:0]     acc_sum;
    logic [TOTAL_BITS-1:0] frame_inc;
    logic                  adv_step;

    logic [NB-1:0]   div_divisor;
    logic [NB-1:0]   div_dividend;
    logic [NB:0]     div_shift;
    logic            div_ge;
    logic [NB-1:0]   div_rem_step;
    logic [NB-1:0]   div_quo_step;
    logic            div_last;
    logic            div_active;
    logic            div_load;

    logic [NB:0]            mul_a;
    logic [SIDE_BITS-1:0]   mul_b;
    logic [PROD_BITS-1:0]   mul_prod;

    logic [EXT_BITS-1:0] ext_w;
    logic [EXT_BITS-1:0] ext_h;

    spr_anim_pkg::state_t geo_entry;

    always_comb begin
        if (frame_width_reg == '0) begin
            side_w = SIDE_BITS'(1);
        end else if (frame_width_reg > spr_anim_pkg::MAX_SIDE) begin
            side_w = spr_anim_pkg::MAX_SIDE;
        end else begin
            side_w = frame_width_reg;
        end
        if (frame_height_reg == '0) begin
            side_h = SIDE_BITS'(1);
        end else if (frame_height_reg > spr_anim_pkg::MAX_SIDE) begin
            side_h = spr_anim_pkg::MAX_SIDE;
        end else begin
            side_h = frame_height_reg;
        end
        if (frame_total_reg == '0) begin
            total_wide = 32'd1;
        end else if (32'(frame_total_reg) > 32'(MAX_FRAMES)) begin
            total_wide = 32'(MAX_FRAMES);
        end else begin
            total_wide = 32'(frame_total_reg);
        end
    end

    assign total_eff     = TOTAL_BITS'(total_wide);
    assign start_col_src = NB'(COORD_BITS'(start_x_reg));
    assign start_row_src = NB'(COORD_BITS'(start_y_reg));
    assign sheet_src     = NB'(SW_BITS'(sheet_width_reg));
    assign dur_raw       = TIME_BITS'(frame_duration_reg);
    assign dur_eff       = (dur_raw == '0) ? ACC_BITS'(1) : ACC_BITS'(dur_raw);
    assign acc_sum       = {1'b0, accum_reg} + (ACC_BITS + 1)'(TIME_BITS'(s_data.delta_time));
    assign frame_inc     = {1'b0, frame_reg} + TOTAL_BITS'(1);
    assign geo_entry     = geom_valid_reg ? spr_anim_pkg::ST_DIV_FR : spr_anim_pkg::ST_DIV_SX;
    assign adv_step      = (state_reg == spr_anim_pkg::ST_ADV) && (accum_reg >= dur_eff);

    assign div_active = (state_reg == spr_anim_pkg::ST_DIV_SX) ||
                        (state_reg == spr_anim_pkg::ST_DIV_SY) ||
                        (state_reg == spr_anim_pkg::ST_DIV_SW) ||
                        (state_reg == spr_anim_pkg::ST_DIV_FR);
    assign div_shift    = {rem_reg, quo_reg[NB-1]};
    assign div_ge       = div_shift >= {1'b0, div_divisor};
    assign div_rem_step = div_ge ? NB'(div_shift - {1'b0, div_divisor}) : div_shift[NB-1:0];
    assign div_quo_step = {quo_reg[NB-2:0], div_ge};
    assign div_last     = cnt_reg == CNT_BITS'(NB - 1);

    always_comb begin
        case (state_reg)
            spr_anim_pkg::ST_DIV_SY: div_divisor = NB'(side_h);
            spr_anim_pkg::ST_DIV_FR: div_divisor = cols_reg;
            default:                 div_divisor = NB'(side_w);
        endcase
        case (state_next)
            spr_anim_pkg::ST_DIV_SX: div_dividend = start_col_src;
            spr_anim_pkg::ST_DIV_SY: div_dividend = start_row_src;
            spr_anim_pkg::ST_DIV_SW: div_dividend = sheet_src;
            default:                 div_dividend = NB'(frame_next);
        endcase
    end

    assign div_load = (state_next != state_reg) &&
                      ((state_next == spr_anim_pkg::ST_DIV_SX) ||
                       (state_next == spr_anim_pkg::ST_DIV_SY) ||
                       (state_next == spr_anim_pkg::ST_DIV_SW) ||
                       (state_next == spr_anim_pkg::ST_DIV_FR));

    always_comb begin
        if (state_reg == spr_anim_pkg::ST_MUL_Y) begin
            mul_a = (NB + 1)'(rowb_reg) + (NB + 1)'(fq_reg);
            mul_b = side_h;
        end else begin
            mul_a = (NB + 1)'(colb_reg) + (NB + 1)'(fr_reg);
            mul_b = side_w;
        end
    end

    assign mul_prod = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    assign ext_w    = EXT_BITS'(side_w);
    assign ext_h    = EXT_BITS'(side_h);

    always_comb begin
        state_next      = state_reg;
        frame_next      = frame_reg;
        accum_next      = accum_reg;
        running_next    = running_reg;
        adv_next        = adv_reg;
        geom_valid_next = geom_valid_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        colb_next       = colb_reg;
        rowb_next       = rowb_reg;
        cols_next       = cols_reg;
        fq_next         = fq_reg;
        fr_next         = fr_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg && !m_ready;

        case (state_reg)
            spr_anim_pkg::ST_IDLE: begin
                if (s_valid) begin
                    adv_next   = 1'b0;
                    state_next = geo_entry;
                    case (s_data.req_type)
                        spr_anim_pkg::REQ_TICK: begin
                            if (running_reg) begin
                                accum_next = acc_sum[ACC_BITS] ? '1 : acc_sum[ACC_BITS-1:0];
                                state_next = spr_anim_pkg::ST_ADV;
                            end
                        end
                        spr_anim_pkg::REQ_PLAY: begin
                            running_next = 1'b1;
                        end
                        spr_anim_pkg::REQ_PAUSE: begin
                            running_next = 1'b0;
                        end
                        spr_anim_pkg::REQ_STOP: begin
                            running_next = 1'b0;
                            frame_next   = '0;
                            accum_next   = '0;
                            adv_next     = frame_reg != '0;
                        end
                        spr_anim_pkg::REQ_RESTART: begin
                            running_next = 1'b1;
                            frame_next   = '0;
                            accum_next   = '0;
                            adv_next     = frame_reg != '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            spr_anim_pkg::ST_ADV: begin
                if (accum_reg >= dur_eff) begin
                    accum_next = accum_reg - dur_eff;
                    if (frame_inc >= total_eff) begin
                        if (mode_bits_reg[0]) begin
                            frame_next = '0;
                        end else begin
                            frame_next   = FRAME_BITS'(total_eff - TOTAL_BITS'(1));
                            running_next = 1'b0;
                        end
                    end else begin
                        frame_next = FRAME_BITS'(frame_inc);
                    end
                    adv_next = frame_next != frame_reg;
                end
                state_next = geo_entry;
            end
            spr_anim_pkg::ST_DIV_SX: begin
                if (div_last) begin
                    colb_next  = div_quo_step;
                    state_next = spr_anim_pkg::ST_DIV_SY;
                end
            end
            spr_anim_pkg::ST_DIV_SY: begin
                if (div_last) begin
                    rowb_next  = div_quo_step;
                    state_next = spr_anim_pkg::ST_DIV_SW;
                end
            end
            spr_anim_pkg::ST_DIV_SW: begin
                if (div_last) begin
                    cols_next       = (div_quo_step == '0) ? NB'(1) : div_quo_step;
                    geom_valid_next = 1'b1;
                    state_next      = spr_anim_pkg::ST_DIV_FR;
                end
            end
            spr_anim_pkg::ST_DIV_FR: begin
                if (div_last) begin
                    fq_next    = div_quo_step;
                    fr_next    = div_rem_step;
                    state_next = spr_anim_pkg::ST_MUL_X;
                end
            end
            spr_anim_pkg::ST_MUL_X: begin
                pos_x_next = mul_prod[POS_BITS-1:0];
                state_next = spr_anim_pkg::ST_MUL_Y;
            end
            spr_anim_pkg::ST_MUL_Y: begin
                pos_y_next = mul_prod[POS_BITS-1:0];
                state_next = spr_anim_pkg::ST_OUT;
            end
            spr_anim_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.rect_left   = mode_bits_reg[1] ?
                                           pos_x_reg + POS_BITS'(side_w) : pos_x_reg;
                    out_next.rect_top    = mode_bits_reg[2] ?
                                           pos_y_reg + POS_BITS'(side_h) : pos_y_reg;
                    out_next.rect_width  = mode_bits_reg[1] ? EXT_BITS'(0) - ext_w : ext_w;
                    out_next.rect_height = mode_bits_reg[2] ? EXT_BITS'(0) - ext_h : ext_h;
                    out_next.frame_index    = 8'(frame_reg);
                    out_next.playing        = running_reg;
                    out_next.frame_advanced = adv_reg;
                    m_valid_next = 1'b1;
                    state_next   = spr_anim_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = spr_anim_pkg::ST_IDLE;
            end
        endcase

        if (div_load) begin
            rem_next = '0;
            quo_next = div_dividend;
            cnt_next = '0;
        end else if (div_active) begin
            rem_next = div_rem_step;
            quo_next = div_quo_step;
            cnt_next = cnt_reg + CNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_total_reg    <= 9'd1;
            frame_width_reg    <= SIDE_BITS'(1);
            frame_height_reg   <= SIDE_BITS'(1);
            start_x_reg        <= '0;
            start_y_reg        <= '0;
            sheet_width_reg    <= '0;
            frame_duration_reg <= 24'd83333;
            mode_bits_reg      <= 3'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                spr_anim_pkg::REG_FRAME_TOTAL:    frame_total_reg    <= cfg_wdata[8:0];
                spr_anim_pkg::REG_FRAME_WIDTH:    frame_width_reg    <= cfg_wdata[10:0];
                spr_anim_pkg::REG_FRAME_HEIGHT:   frame_height_reg   <= cfg_wdata[10:0];
                spr_anim_pkg::REG_START_X:        start_x_reg        <= cfg_wdata[11:0];
                spr_anim_pkg::REG_START_Y:        start_y_reg        <= cfg_wdata[11:0];
                spr_anim_pkg::REG_SHEET_WIDTH:    sheet_width_reg    <= cfg_wdata[12:0];
                spr_anim_pkg::REG_FRAME_DURATION: frame_duration_reg <= cfg_wdata[23:0];
                spr_anim_pkg::REG_MODE_BITS:      mode_bits_reg      <= cfg_wdata[2:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= spr_anim_pkg::ST_IDLE;
            frame_reg      <= '0;
            accum_reg      <= '0;
            running_reg    <= 1'b0;
            adv_reg        <= 1'b0;
            geom_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            frame_reg      <= frame_next;
            accum_reg      <= accum_next;
            running_reg    <= running_next;
            adv_reg        <= adv_next;
            geom_valid_reg <= cfg_wr_en ? 1'b0 : geom_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        colb_reg  <= colb_next;
        rowb_reg  <= rowb_next;
        cols_reg  <= cols_next;
        fq_reg    <= fq_next;
        fr_reg    <= fr_next;
        pos_x_reg <= pos_x_next;
        pos_y_reg <= pos_y_next;
        out_reg   <= out_next;
    end

    assign s_ready = state_reg == spr_anim_pkg::ST_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    `ASSERT_IMPLIES(a_div_rem_bound, aclk, aresetn, div_active, rem_reg < div_divisor)

    `ASSERT_IMPLIES(a_cols_nonzero, aclk, aresetn, state_reg == spr_anim_pkg::ST_DIV_FR, cols_reg != '0)

    `ASSERT_NEXT(a_adv_in_range, aclk, aresetn, adv_step, TOTAL_BITS'(frame_reg) < total_eff)

    `ASSERT_NEXT(a_out_holds, aclk, aresetn, (state_reg == spr_anim_pkg::ST_OUT) && m_valid_reg && !m_ready, state_reg == spr_anim_pkg::ST_OUT)

endmodule

`default_nettype wire
